FILE: rtl/lmlt_pkg.sv
// ----------------------------------------------------------------------------
// lmlt_pkg
// Shared types and constants for the LCD mode and line timing unit.
// ----------------------------------------------------------------------------
package lmlt_pkg;

    // Mode codes as reported on the status port
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LCD_ON        = 3'd0,
        CFG_HBLANK_INT_EN = 3'd1,
        CFG_VBLANK_INT_EN = 3'd2,
        CFG_OAM_INT_EN    = 3'd3,
        CFG_LYC_INT_EN    = 3'd4,
        CFG_LYC_VALUE     = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_W      = 9;
    localparam int LINE_W     = 8;

    // Mode lengths in dot clocks
    localparam logic [CNT_W-1:0] CLKS_MODE2 = 9'd80;
    localparam logic [CNT_W-1:0] CLKS_MODE3 = 9'd172;
    localparam logic [CNT_W-1:0] CLKS_MODE0 = 9'd204;
    localparam logic [CNT_W-1:0] CLKS_MODE1 = 9'd456;

    localparam logic [LINE_W-1:0] LAST_VISIBLE_LINE = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

    typedef struct packed {
        logic              lcd_on;
        logic              hblank_int_en;
        logic              vblank_int_en;
        logic              oam_int_en;
        logic              lyc_int_en;
        logic [LINE_W-1:0] lyc_value;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [LINE_W-1:0] line;
        logic              lyc_match;
        logic              stat_irq;
        logic              vblank_irq;
        logic              frame_done;
    } t_result;

endpackage

FILE: rtl/lmlt_if.sv
// ----------------------------------------------------------------------------
// lmlt_if
// Handshake channels of the LCD mode and line timing unit.
// ----------------------------------------------------------------------------
interface lmlt_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface lmlt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] line;
    logic       lyc_match;
    logic       stat_irq;
    logic       vblank_irq;
    logic       frame_done;

    modport source (output valid, output mode, output line, output lyc_match,
                    output stat_irq, output vblank_irq, output frame_done,
                    input ready);
    modport sink   (input valid, input mode, input line, input lyc_match,
                    input stat_irq, input vblank_irq, input frame_done,
                    output ready);
endinterface

interface lmlt_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/lcd_mode_line_timing_unit.sv
// ----------------------------------------------------------------------------
// lcd_mode_line_timing_unit
// LCD mode and line sequencer with status and vblank requests.
// ----------------------------------------------------------------------------
// A result beat is registered when its tick beat is accepted.
// Throughput: one tick beat per cycle; the result register refills in the
// cycle its beat is taken, so only output back-pressure stalls the input.
// Reset (synchronous, active low): mode 1 with an 80-dot limit, line 0,
// dot count 0, compare flag clear, all configuration registers 0.
// ----------------------------------------------------------------------------
module lcd_mode_line_timing_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmlt_in_if.sink    i_in,
    lmlt_cfg_if.sink   i_cfg,
    lmlt_out_if.source o_out
);
    import lmlt_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_can_load;
    logic    w_accept;

    // Take a tick whenever the result register is free or being drained
    assign i_in.ready = w_can_load;
    assign w_accept   = i_in.valid && w_can_load;

    // Configuration bank: always ready; the user must write it only while idle
    lmlt_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Timing state: advance on an accepted beat with tick set; an idle
    // beat reports the current state with all pulses low
    lmlt_timing u_timing (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_tick   (i_in.tick),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Hold the result until the sink takes it
    lmlt_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

endmodule

FILE: rtl/lmlt_cfg_regs.sv
// ----------------------------------------------------------------------------
// lmlt_cfg_regs
// Configuration register bank; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module lmlt_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lmlt_cfg_if.sink      i_cfg,
    output lmlt_pkg::t_cfg o_cfg
);
    import lmlt_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_LCD_ON:        n_cfg.lcd_on        = i_cfg.data[0];
                CFG_HBLANK_INT_EN: n_cfg.hblank_int_en = i_cfg.data[0];
                CFG_VBLANK_INT_EN: n_cfg.vblank_int_en = i_cfg.data[0];
                CFG_OAM_INT_EN:    n_cfg.oam_int_en    = i_cfg.data[0];
                CFG_LYC_INT_EN:    n_cfg.lyc_int_en    = i_cfg.data[0];
                CFG_LYC_VALUE:     n_cfg.lyc_value     = i_cfg.data;
                default:           n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/lmlt_timing.sv
// ----------------------------------------------------------------------------
// lmlt_timing
// Dot counter, mode sequencer and line counter; forms one result per beat.
// ----------------------------------------------------------------------------
module lmlt_timing (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_tick,
    input  lmlt_pkg::t_cfg    i_cfg,
    output lmlt_pkg::t_result o_result
);
    import lmlt_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_limit, n_limit;
    t_mode             r_mode,  n_mode;
    logic [LINE_W-1:0] r_line,  n_line;
    logic              r_flag,  n_flag;

    logic [CNT_W-1:0]  w_count_inc;
    logic [LINE_W-1:0] w_line_inc;
    logic              w_stat_cond;
    logic              w_stat;
    logic              w_vbl;
    logic              w_done;

    assign w_count_inc = r_count + 9'd1;
    assign w_line_inc  = r_line + 8'd1;

    // Status condition sampled on the mode and line before the transition
    assign w_stat_cond = (i_cfg.oam_int_en    && (r_mode == MODE_OAM))
                      || (i_cfg.hblank_int_en && (r_mode == MODE_HBLANK))
                      || (i_cfg.vblank_int_en && (r_mode == MODE_VBLANK))
                      || (i_cfg.lyc_int_en    && (r_line == i_cfg.lyc_value));

    always_comb begin
        n_count = r_count;
        n_limit = r_limit;
        n_mode  = r_mode;
        n_line  = r_line;
        n_flag  = r_flag;
        w_stat  = 1'b0;
        w_vbl   = 1'b0;
        w_done  = 1'b0;
        if (i_accept && i_tick) begin
            n_count = w_count_inc;
            if (w_count_inc >= r_limit) begin
                n_count = '0;
                w_stat  = i_cfg.lcd_on && w_stat_cond;
                case (r_mode)
                    MODE_OAM: begin
                        n_mode  = MODE_XFER;
                        n_limit = CLKS_MODE3;
                    end
                    MODE_XFER: begin
                        n_mode  = MODE_HBLANK;
                        n_limit = CLKS_MODE0;
                    end
                    MODE_HBLANK: begin
                        n_mode  = MODE_OAM;
                        n_limit = CLKS_MODE2;
                        n_line  = w_line_inc;
                        n_flag  = (w_line_inc == i_cfg.lyc_value);
                        if (w_line_inc > LAST_VISIBLE_LINE) begin
                            n_mode  = MODE_VBLANK;
                            n_limit = CLKS_MODE1;
                            w_vbl   = i_cfg.lcd_on;
                        end
                    end
                    default: begin
                        // vblank keeps its current limit
                        n_line = w_line_inc;
                        n_flag = (w_line_inc == i_cfg.lyc_value);
                        if (w_line_inc > LAST_LINE) begin
                            w_done  = 1'b1;
                            n_line  = '0;
                            n_flag  = (i_cfg.lyc_value == '0);
                            n_mode  = MODE_OAM;
                            n_limit = CLKS_MODE2;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.mode       = n_mode;
        o_result.line       = n_line;
        o_result.lyc_match  = n_flag;
        o_result.stat_irq   = w_stat;
        o_result.vblank_irq = w_vbl;
        o_result.frame_done = w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= CLKS_MODE2;
            r_mode  <= MODE_VBLANK;
            r_line  <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_limit <= n_limit;
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_flag  <= n_flag;
        end
    end

endmodule

FILE: rtl/lmlt_out_reg.sv
// ----------------------------------------------------------------------------
// lmlt_out_reg
// Result register; refills in the same cycle its beat is taken.
// ----------------------------------------------------------------------------
module lmlt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lmlt_pkg::t_result i_result,
    output logic              o_can_load,
    lmlt_out_if.source        o_out
);
    import lmlt_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_can_load = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.mode       = r_result.mode;
    assign o_out.line       = r_result.line;
    assign o_out.lyc_match  = r_result.lyc_match;
    assign o_out.stat_irq   = r_result.stat_irq;
    assign o_out.vblank_irq = r_result.vblank_irq;
    assign o_out.frame_done = r_result.frame_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: bench/lmlt_timing_check_pkg.sv
// ----------------------------------------------------------------------------
// lmlt_timing_check_pkg
// Mode, line and request tracker for the LCD mode and line timing bench.
// Predicts the status beat for every tick beat taken by the unit and
// checks the beats that come back, in order, field by field.
// ----------------------------------------------------------------------------
package lmlt_timing_check_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import lmlt_pkg::*;

    class lcd_timing_scoreboard;

        // register copy and timing state
        t_cfg              regs;
        logic [CNT_W-1:0]  dots;
        logic [CNT_W-1:0]  dot_limit;
        t_mode             mode;
        logic [LINE_W-1:0] line;
        logic              lyc_flag;

        t_result           expected_status[$];

        int unsigned errors;
        int unsigned n_ticks;
        int unsigned n_checked;
        int unsigned n_frames;
        int unsigned n_vblank;
        int unsigned n_stat;

        function new();
            regs      = '0;
            dots      = '0;
            dot_limit = CLKS_MODE2;
            mode      = MODE_VBLANK;
            line      = '0;
            lyc_flag  = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LCD_ON:        regs.lcd_on        = data[0];
                CFG_HBLANK_INT_EN: regs.hblank_int_en = data[0];
                CFG_VBLANK_INT_EN: regs.vblank_int_en = data[0];
                CFG_OAM_INT_EN:    regs.oam_int_en    = data[0];
                CFG_LYC_INT_EN:    regs.lyc_int_en    = data[0];
                CFG_LYC_VALUE:     regs.lyc_value     = data;
                default:           ;
            endcase
        endfunction

        function void set_line(logic [LINE_W-1:0] v);
            line     = v;
            lyc_flag = (line == regs.lyc_value);
        endfunction

        // status condition of the mode being left, compare on the old line
        function logic status_hit();
            return (regs.oam_int_en    && mode == MODE_OAM)    ||
                   (regs.hblank_int_en && mode == MODE_HBLANK) ||
                   (regs.vblank_int_en && mode == MODE_VBLANK) ||
                   (regs.lyc_int_en    && line == regs.lyc_value);
        endfunction

        function t_result advance_dot(bit t);
            t_result r;
            logic    ints;
            r = '0;
            if (t) begin
                dots = dots + 1'b1;
                if (dots >= dot_limit) begin
                    ints = regs.lcd_on;
                    if (ints) r.stat_irq = status_hit();
                    case (mode)
                        MODE_OAM: begin
                            mode      = MODE_XFER;
                            dot_limit = CLKS_MODE3;
                        end
                        MODE_XFER: begin
                            mode      = MODE_HBLANK;
                            dot_limit = CLKS_MODE0;
                        end
                        MODE_HBLANK: begin
                            mode      = MODE_OAM;
                            dot_limit = CLKS_MODE2;
                            set_line(line + 8'd1);
                            if (line > LAST_VISIBLE_LINE) begin
                                mode      = MODE_VBLANK;
                                dot_limit = CLKS_MODE1;
                                if (ints) r.vblank_irq = 1'b1;
                            end
                        end
                        default: begin
                            // vblank keeps whatever limit is current
                            set_line(line + 8'd1);
                            if (line > LAST_LINE) begin
                                r.frame_done = 1'b1;
                                set_line('0);
                                mode      = MODE_OAM;
                                dot_limit = CLKS_MODE2;
                            end
                        end
                    endcase
                    dots = '0;
                end
            end
            r.mode      = mode;
            r.line      = line;
            r.lyc_match = lyc_flag;
            return r;
        endfunction

        function void note_tick(bit t);
            t_result r;
            r = advance_dot(t);
            n_ticks++;
            if (r.frame_done) n_frames++;
            if (r.vblank_irq) n_vblank++;
            if (r.stat_irq)   n_stat++;
            expected_status.push_back(r);
        endfunction

        function void compare_field(string field, logic [8:0] want, logic [8:0] seen);
            if (want !== seen) begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, seen);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_checked++;
            if (expected_status.size() == 0) begin
                errors++;
                $display("%0t ns: status beat with nothing expected, actual mode %0d line %0d",
                         $time, got.mode, got.line);
                return;
            end
            want = expected_status.pop_front();
            compare_field("mode",       want.mode,       got.mode);
            compare_field("line",       want.line,       got.line);
            compare_field("lyc_match",  want.lyc_match,  got.lyc_match);
            compare_field("stat_irq",   want.stat_irq,   got.stat_irq);
            compare_field("vblank_irq", want.vblank_irq, got.vblank_irq);
            compare_field("frame_done", want.frame_done, got.frame_done);
        endfunction

    endclass

endpackage

FILE: bench/tb_lcd_mode_line_timing_unit.sv
// ----------------------------------------------------------------------------
// tb_lcd_mode_line_timing_unit
// Self-checking bench for the LCD mode and line timing unit.
// Drives tick beats through several register settings, from the reset quirk
// through the early 80-dot vblank lines with compare hits and masked requests,
// and checks every status beat against an in-bench tracker of modes, lines
// and requests.
// ----------------------------------------------------------------------------
module tb_lcd_mode_line_timing_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import lmlt_pkg::*;
    import lmlt_timing_check_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lmlt_in_if  in_if();
    lmlt_cfg_if cfg_if();
    lmlt_out_if out_if();

    lcd_timing_scoreboard sb;

    lcd_mode_line_timing_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stretch of the run with no idling on either side: both channels
    // run flat out so the unit sees back-to-back beats.
    function automatic bit calm();
        return sb.n_checked >= 400 && sb.n_checked < 750;
    endfunction

    // Sample every handshake at the rising edge. Note the tick beat before
    // checking the status beat, so the tracker is always ahead of the unit.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n === 1'b1) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready)
                sb.note_tick(in_if.tick);
            if (out_if.valid && out_if.ready) begin
                got.mode       = t_mode'(out_if.mode);
                got.line       = out_if.line;
                got.lyc_match  = out_if.lyc_match;
                got.stat_irq   = out_if.stat_irq;
                got.vblank_irq = out_if.vblank_irq;
                got.frame_done = out_if.frame_done;
                sb.check_result(got);
            end
        end
    end

    // Status receiver: drop ready at random, and once early on hold it low
    // for a long stretch so the result register fills and stalls the input.
    initial begin : status_sink
        int unsigned held;
        bit          hold_done;
        hold_done    = 1'b0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sb.n_checked >= 40) begin
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                for (held = 0; held < 200; held++) @(negedge i_clk);
            end else begin
                out_if.ready <= calm() || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    // Offer one tick beat, possibly after a few idle cycles, and hold it
    // until taken. Starts and ends just after a falling edge.
    task automatic send_tick(input bit t);
        while (!calm() && $urandom_range(0, 99) < 27) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.tick  <= t;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random ticks, pct percent of them advancing the dot clock
    task automatic run_ticks(input int unsigned count, input int unsigned pct);
        repeat (count) send_tick($urandom_range(0, 99) < pct);
    endtask

    // Stop offering and wait for every outstanding status beat
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.expected_status.size() != 0) @(negedge i_clk);
    endtask

    // Raise (or hold) the write and wait for it to be taken; valid is
    // dropped once by load_regs after the whole sequence.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Reprogramme every register while the unit is idle. Single-bit
    // registers get random upper bits, which must be masked off, and the
    // two unused indexes get junk that must be ignored.
    task automatic load_regs(input t_cfg c);
        drain();
        repeat (2) @(negedge i_clk);
        write_reg(3'd6, CFG_DATA_W'($urandom));
        write_reg(CFG_LCD_ON,        {7'($urandom), c.lcd_on});
        write_reg(CFG_HBLANK_INT_EN, {7'($urandom), c.hblank_int_en});
        write_reg(CFG_VBLANK_INT_EN, {7'($urandom), c.vblank_int_en});
        write_reg(CFG_OAM_INT_EN,    {7'($urandom), c.oam_int_en});
        write_reg(CFG_LYC_INT_EN,    {7'($urandom), c.lyc_int_en});
        write_reg(CFG_LYC_VALUE,     c.lyc_value);
        write_reg(3'd7, CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_cfg c;
        sb           = new();
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.tick   = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset state and idle beats: no tick, then a run of ticks, then idle
        // again. All registers are still 0, so no requests may appear.
        repeat (3)  send_tick(1'b0);
        repeat (18) send_tick(1'b1);
        repeat (3)  send_tick(1'b0);

        // Reset quirk: vblank lines step every 80 dots.
        // Vblank status on every vblank transition, compare on line 3.
        c               = '0;
        c.lcd_on        = 1'b1;
        c.vblank_int_en = 1'b1;
        c.lyc_int_en    = 1'b1;
        c.lyc_value     = 8'd3;
        load_regs(c);
        run_ticks(300, 95);

        // OAM and hblank status on, which stay quiet in vblank; compare
        // on a later vblank line.
        c               = '0;
        c.lcd_on        = 1'b1;
        c.hblank_int_en = 1'b1;
        c.oam_int_en    = 1'b1;
        c.lyc_int_en    = 1'b1;
        c.lyc_value     = 8'd5;
        load_regs(c);
        run_ticks(250, 90);

        // LCD off with every enable set: timing runs, requests stay masked.
        // Pause mid-way until every status beat has come back.
        c               = '1;
        c.lcd_on        = 1'b0;
        c.lyc_value     = 8'd255;
        load_regs(c);
        run_ticks(150, 70);
        drain();
        run_ticks(150, 70);

        // Everything on; the compare flag stays stale until the next line
        // write, while the compare condition uses the new value at once.
        c               = '1;
        c.lyc_value     = 8'd9;
        load_regs(c);
        run_ticks(200, 80);

        drain();
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d tick beats up to line %0d, %0d vblank entries",
                 sb.n_ticks, sb.line, sb.n_vblank);
        $display("and %0d status requests, with the LCD both on and off; %0d errors",
                 sb.n_stat, sb.errors);
        if (sb.errors == 0 && sb.expected_status.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin : watchdog
        #30_000_000;
        $display("Timeout waiting for the unit");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
